/* src/lpht_pkg.sv */
// Shared constants and codes of the linear probing hash table.
`timescale 1ns / 1ps
package lpht_pkg;

	localparam int CAPACITY   = 256;
	localparam int DATA_WIDTH = 32;
	localparam int KEY_W      = 32;
	localparam int SLOT_W     = $clog2(CAPACITY);
	localparam int PROBE_W    = SLOT_W + 1;
	localparam int ENTRY_W    = KEY_W + DATA_WIDTH;

	localparam logic [1:0] ACT_SET    = 2'd0;
	localparam logic [1:0] ACT_GET    = 2'd1;
	localparam logic [1:0] ACT_REMOVE = 2'd2;

	localparam logic [2:0] ST_INSERTED  = 3'd0;
	localparam logic [2:0] ST_UPDATED   = 3'd1;
	localparam logic [2:0] ST_FOUND     = 3'd2;
	localparam logic [2:0] ST_REMOVED   = 3'd3;
	localparam logic [2:0] ST_NOT_FOUND = 3'd4;
	localparam logic [2:0] ST_FULL      = 3'd5;

endpackage

/* src/lpht_hash.sv */
// Home slot: key modulo (CAPACITY-1) by folding slot-wide chunks.
`timescale 1ns / 1ps
module lpht_hash (
	input  logic                        clk,
	input  logic [lpht_pkg::KEY_W-1:0]  key,
	output logic [lpht_pkg::SLOT_W-1:0] home
);
	localparam int SW     = lpht_pkg::SLOT_W;
	localparam int NCHUNK = (lpht_pkg::KEY_W + SW - 1) / SW;
	localparam int SUM_W  = SW + $clog2(NCHUNK);
	localparam logic [SW:0] MODULUS = (SW + 1)'(lpht_pkg::CAPACITY - 1);

	logic [SUM_W-1:0] sum_c;
	logic [SUM_W-1:0] sum_s1;
	logic [SW:0]      fold;

	always_comb begin
		sum_c = '0;
		for (int i = 0; i < NCHUNK; i++) begin
			sum_c = sum_c + SUM_W'(SW'(key >> (i * SW)));
		end
	end

	always_ff @(posedge clk) begin
		sum_s1 <= sum_c;
	end

	assign fold = (SW + 1)'(sum_s1[SW-1:0]) + (SW + 1)'(sum_s1 >> SW);
	assign home = (fold >= MODULUS) ? SW'(fold - MODULUS) : SW'(fold);

endmodule

/* src/lpht_ram.sv */
// Single-port synchronous RAM with registered read data.
`timescale 1ns / 1ps
module lpht_ram #(
	parameter int ADDR_W = 8,
	parameter int DATA_W = 64
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] addr,
	input  logic [DATA_W-1:0] wdata,
	output logic [DATA_W-1:0] rdata
);
	logic [DATA_W-1:0] mem [2**ADDR_W];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

/* src/linear_probe_hash_table.sv */
// Top level of the linear probing hash table: sequencer, valid bits and result register.
//
// Steps: from accept, a hash sum state and a hash fold state, then for each slot probed
// one RAM read state and one compare state, then the result state.
// Throughput: one item at a time; the next item is taken once the result is registered.
// Reset: arst_n clears all valid bits, the entry count and the longest probe length
// at once; key and data RAM contents are not cleared.
`timescale 1ns / 1ps
module linear_probe_hash_table (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,  // key[31:0], data_in[63:32]
	input  logic [1:0]  s_axis_tuser,  // action[1:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,  // data_out[31:0], entry_count[40:32], zero[47:41]
	output logic [2:0]  m_axis_tuser   // status[2:0]
);
	localparam int CAP  = lpht_pkg::CAPACITY;
	localparam int SW   = lpht_pkg::SLOT_W;
	localparam int PW   = lpht_pkg::PROBE_W;
	localparam int KW   = lpht_pkg::KEY_W;
	localparam int DW   = lpht_pkg::DATA_WIDTH;
	localparam int EW   = lpht_pkg::ENTRY_W;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SUM  = 3'd1;
	localparam logic [2:0] S_FOLD = 3'd2;
	localparam logic [2:0] S_RD   = 3'd3;
	localparam logic [2:0] S_CHK  = 3'd4;
	localparam logic [2:0] S_DONE = 3'd5;

	logic [2:0]      state_q;
	logic [1:0]      action_q;
	logic [KW-1:0]   key_q;
	logic [DW-1:0]   data_q;
	logic [SW-1:0]   idx_q;
	logic [PW-1:0]   probe_q;
	logic [PW-1:0]   probe_nxt;
	logic [PW-1:0]   longest_q;
	logic [PW-1:0]   count_q;
	logic [CAP-1:0]  valid_q;
	logic [2:0]      res_status_q;
	logic [DW-1:0]   res_data_q;
	logic            out_valid_q;
	logic [2:0]      out_status_q;
	logic [31:0]     out_data_q;
	logic [PW-1:0]   out_count_q;

	logic [SW-1:0]   home;
	logic            ram_we;
	logic [EW-1:0]   ram_rdata;
	logic [KW-1:0]   rd_key;
	logic [DW-1:0]   rd_data;
	logic            slot_vld;
	logic            key_hit;
	logic            in_fire;

	lpht_hash u_hash (
		.clk  (clk),
		.key  (key_q),
		.home (home)
	);

	lpht_ram #(
		.ADDR_W (SW),
		.DATA_W (EW)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (idx_q),
		.wdata ({key_q, data_q}),
		.rdata (ram_rdata)
	);

	assign rd_key    = ram_rdata[EW-1:DW];
	assign rd_data   = ram_rdata[DW-1:0];
	assign slot_vld  = valid_q[idx_q];
	assign key_hit   = (rd_key == key_q);
	assign probe_nxt = probe_q + PW'(1);
	assign in_fire   = s_axis_tvalid && s_axis_tready;
	assign ram_we    = (state_q == S_CHK) && (action_q == lpht_pkg::ACT_SET) &&
	                   (!slot_vld || key_hit);

	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_status_q;
	assign m_axis_tdata  = {7'd0, 9'(out_count_q), out_data_q};

	always_ff @(posedge clk) begin
		if (in_fire) begin
			action_q <= s_axis_tuser;
			key_q    <= s_axis_tdata[31:0];
			data_q   <= DW'(s_axis_tdata[63:32]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			idx_q        <= '0;
			probe_q      <= '0;
			longest_q    <= '0;
			count_q      <= '0;
			valid_q      <= '0;
			res_status_q <= lpht_pkg::ST_NOT_FOUND;
			res_data_q   <= '0;
			out_valid_q  <= 1'b0;
			out_status_q <= lpht_pkg::ST_NOT_FOUND;
			out_data_q   <= '0;
			out_count_q  <= '0;
		end else begin
			if (out_valid_q && m_axis_tready && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						state_q <= S_SUM;
					end
				end
				S_SUM: begin
					state_q <= S_FOLD;
				end
				S_FOLD: begin
					idx_q        <= home;
					probe_q      <= '0;
					res_status_q <= lpht_pkg::ST_NOT_FOUND;
					res_data_q   <= '0;
					if (action_q == lpht_pkg::ACT_SET) begin
						state_q <= S_RD;
					end else if ((action_q == lpht_pkg::ACT_GET ||
					              action_q == lpht_pkg::ACT_REMOVE) && longest_q != '0) begin
						state_q <= S_RD;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_RD: begin
					state_q <= S_CHK;
				end
				S_CHK: begin
					idx_q   <= (idx_q == SW'(CAP - 1)) ? '0 : idx_q + SW'(1);
					probe_q <= probe_nxt;
					if (action_q == lpht_pkg::ACT_SET) begin
						if (!slot_vld || key_hit || probe_nxt == PW'(CAP)) begin
							state_q <= S_DONE;
							if (probe_nxt > longest_q) begin
								longest_q <= probe_nxt;
							end
						end else begin
							state_q <= S_RD;
						end
						if (!slot_vld) begin
							valid_q[idx_q] <= 1'b1;
							count_q        <= count_q + PW'(1);
							res_status_q   <= lpht_pkg::ST_INSERTED;
						end else if (key_hit) begin
							res_status_q <= lpht_pkg::ST_UPDATED;
						end else if (probe_nxt == PW'(CAP)) begin
							res_status_q <= lpht_pkg::ST_FULL;
						end
					end else begin
						if (slot_vld && key_hit) begin
							state_q <= S_DONE;
							if (action_q == lpht_pkg::ACT_GET) begin
								res_status_q <= lpht_pkg::ST_FOUND;
								res_data_q   <= rd_data;
							end else begin
								res_status_q   <= lpht_pkg::ST_REMOVED;
								valid_q[idx_q] <= 1'b0;
								if (count_q != '0) begin
									count_q <= count_q - PW'(1);
								end
							end
						end else if (probe_nxt >= longest_q) begin
							state_q <= S_DONE;
						end else begin
							state_q <= S_RD;
						end
					end
				end
				S_DONE: begin
					if (!out_valid_q || m_axis_tready) begin
						out_valid_q  <= 1'b1;
						out_status_q <= res_status_q;
						out_data_q   <= 32'(res_data_q);
						out_count_q  <= count_q;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_accept_starts_hash: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> state_q == S_SUM)
		else $error("accepted item did not start the hash stage");

	a_write_only_on_check: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> state_q == S_CHK && action_q == lpht_pkg::ACT_SET)
		else $error("RAM written outside a set check");

	a_count_changes_on_check: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != $past(count_q) |-> $past(state_q) == S_CHK)
		else $error("entry count changed outside a slot check");

	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= PW'(CAP) && longest_q <= PW'(CAP))
		else $error("entry count or probe length beyond capacity");

	a_probe_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_RD |-> probe_q < PW'(CAP))
		else $error("probe index reached capacity");

	a_longest_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CHK |=> longest_q >= $past(longest_q))
		else $error("longest probe length decreased");

endmodule

/* dv/linear_probe_hash_table_tb.sv */
// Self-checking testbench for the linear probing hash table: driver, monitor and predictor.
`timescale 1ns / 1ps
module linear_probe_hash_table_tb;

	localparam logic [1:0] ACT_UNUSED = 2'd3;
	localparam int DRAIN_CYCLES = 600;
	localparam int PHASE_ITEMS = 330;
	localparam int POOL_SIZE = 48;

	typedef struct {
		logic [1:0]  action;
		logic [31:0] key;
		logic [31:0] data;
		int unsigned idle_pct;
		int unsigned stall_pct;
	} table_op_t;

	typedef struct {
		logic [2:0]  status;
		logic [31:0] data_out;
		logic [8:0]  entry_count;
	} table_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [63:0] s_axis_tdata = '0;  // key[31:0], data_in[63:32]
	logic [1:0]  s_axis_tuser = '0;  // action[1:0]
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [47:0] m_axis_tdata;       // data_out[31:0], entry_count[40:32], zero[47:41]
	logic [2:0]  m_axis_tuser;       // status[2:0]

	table_op_t     pending_ops[$];
	table_result_t expected_results[$];
	table_op_t     op_in_flight;
	table_result_t want_result;
	table_result_t seen_result;
	int unsigned   sink_stall_pct = 0;
	int unsigned   items_accepted = 0;
	int unsigned   total_items = 0;
	int unsigned   mismatch_count = 0;

	bit          tbl_valid[lpht_pkg::CAPACITY];
	logic [31:0] tbl_key[lpht_pkg::CAPACITY];
	logic [31:0] tbl_data[lpht_pkg::CAPACITY];
	int unsigned live_count = 0;
	int unsigned max_probe = 0;

	logic [31:0] key_pool[POOL_SIZE];
	logic [31:0] fill_keys[$];

	linear_probe_hash_table DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser)
	);

	always #4 clk = ~clk;

	function automatic table_result_t apply_table_op(table_op_t op);
		table_result_t r;
		int unsigned slot;
		int unsigned n;
		r.status = lpht_pkg::ST_NOT_FOUND;
		r.data_out = '0;
		slot = op.key % 32'(lpht_pkg::CAPACITY - 1);
		n = 0;
		case (op.action) inside
			lpht_pkg::ACT_SET: begin
				r.status = lpht_pkg::ST_FULL;
				while (n < lpht_pkg::CAPACITY) begin
					n++;
					if (!tbl_valid[slot]) begin
						tbl_valid[slot] = 1'b1;
						tbl_key[slot] = op.key;
						tbl_data[slot] = op.data;
						live_count++;
						r.status = lpht_pkg::ST_INSERTED;
						break;
					end
					if (tbl_key[slot] == op.key) begin
						tbl_data[slot] = op.data;
						r.status = lpht_pkg::ST_UPDATED;
						break;
					end
					slot = (slot >= lpht_pkg::CAPACITY - 1) ? 0 : slot + 1;
				end
				if (n > max_probe)
					max_probe = n;
			end
			lpht_pkg::ACT_GET, lpht_pkg::ACT_REMOVE: begin
				while (n < max_probe && n < lpht_pkg::CAPACITY) begin
					if (tbl_valid[slot] && tbl_key[slot] == op.key) begin
						if (op.action == lpht_pkg::ACT_GET) begin
							r.status = lpht_pkg::ST_FOUND;
							r.data_out = tbl_data[slot];
						end else begin
							tbl_valid[slot] = 1'b0;
							if (live_count > 0)
								live_count--;
							r.status = lpht_pkg::ST_REMOVED;
						end
						break;
					end
					slot = (slot >= lpht_pkg::CAPACITY - 1) ? 0 : slot + 1;
					n++;
				end
			end
			default: ;
		endcase
		r.entry_count = live_count[8:0];
		return r;
	endfunction

	task automatic add_op(logic [1:0] action, logic [31:0] key, logic [31:0] data,
			int unsigned idle_pct, int unsigned stall_pct);
		table_op_t op;
		op.action = action;
		op.key = key;
		op.data = data;
		op.idle_pct = idle_pct;
		op.stall_pct = stall_pct;
		pending_ops.push_back(op);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			s_axis_tuser <= '0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				expected_results.push_back(apply_table_op(op_in_flight));
				items_accepted++;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (pending_ops.size() != 0 &&
						$urandom_range(0, 99) >= pending_ops[0].idle_pct) begin
					op_in_flight = pending_ops.pop_front();
					s_axis_tdata <= {op_in_flight.data, op_in_flight.key};
					s_axis_tuser <= op_in_flight.action;
					s_axis_tvalid <= 1'b1;
					sink_stall_pct <= op_in_flight.stall_pct;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				seen_result.status = m_axis_tuser;
				seen_result.data_out = m_axis_tdata[31:0];
				seen_result.entry_count = m_axis_tdata[40:32];
				if (expected_results.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("unexpected result: status %0d data %h count %0d",
							seen_result.status, seen_result.data_out, seen_result.entry_count);
				end else begin
					want_result = expected_results.pop_front();
					if (seen_result.status !== want_result.status ||
							seen_result.data_out !== want_result.data_out ||
							seen_result.entry_count !== want_result.entry_count) begin
						mismatch_count++;
						if (mismatch_count <= 10)
							$display({"mismatch: expected status %0d data %h count %0d,",
								" got status %0d data %h count %0d"},
								want_result.status, want_result.data_out,
								want_result.entry_count, seen_result.status,
								seen_result.data_out, seen_result.entry_count);
					end
				end
			end
			m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
		end
	end

	initial begin
		int unsigned idle_mode[4];
		int unsigned stall_mode[4];
		int unsigned roll;
		logic [31:0] key;
		logic [31:0] data;
		logic [1:0]  action;

		idle_mode = '{0, 52, 0, 23};
		stall_mode = '{0, 0, 52, 23};

		add_op(lpht_pkg::ACT_GET, 32'h0, 32'h0, 0, 0);
		add_op(lpht_pkg::ACT_REMOVE, 32'h0, 32'h0, 0, 0);
		add_op(lpht_pkg::ACT_SET, 32'h0, 32'h0, 0, 0);
		add_op(lpht_pkg::ACT_SET, 32'd255, 32'hFFFF_FFFF, 0, 0);
		add_op(lpht_pkg::ACT_SET, 32'hFFFF_FFFF, 32'hA5A5_A5A5, 0, 0);
		add_op(lpht_pkg::ACT_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0);
		add_op(lpht_pkg::ACT_SET, 32'd255, 32'h1234_5678, 0, 0);
		add_op(lpht_pkg::ACT_GET, 32'd255, 32'h0, 0, 0);
		add_op(lpht_pkg::ACT_REMOVE, 32'h0, 32'h0, 0, 0);
		// stale duplicate: lands in the freed home slot ahead of the older copy
		add_op(lpht_pkg::ACT_SET, 32'hFFFF_FFFF, 32'h5A5A_5A5A, 0, 0);
		add_op(lpht_pkg::ACT_GET, 32'hFFFF_FFFF, 32'h0, 0, 0);
		add_op(lpht_pkg::ACT_REMOVE, 32'hFFFF_FFFF, 32'h0, 0, 0);
		add_op(lpht_pkg::ACT_GET, 32'hFFFF_FFFF, 32'h0, 0, 0);
		// wrap past the top slot
		add_op(lpht_pkg::ACT_SET, 32'd254, 32'h0000_0001, 0, 0);
		add_op(lpht_pkg::ACT_SET, 32'd509, 32'h8000_0000, 0, 0);
		add_op(lpht_pkg::ACT_SET, 32'd764, 32'h7FFF_FFFF, 0, 0);
		add_op(lpht_pkg::ACT_GET, 32'd764, 32'h0, 0, 0);
		add_op(ACT_UNUSED, 32'd255, 32'hFFFF_FFFF, 0, 0);
		add_op(lpht_pkg::ACT_GET, 32'd7, 32'h0, 0, 0);
		add_op(lpht_pkg::ACT_REMOVE, 32'd764, 32'h0, 0, 0);
		add_op(lpht_pkg::ACT_REMOVE, 32'd509, 32'h0, 0, 0);
		add_op(lpht_pkg::ACT_REMOVE, 32'd254, 32'h0, 0, 0);
		add_op(lpht_pkg::ACT_REMOVE, 32'd255, 32'h0, 0, 0);
		add_op(lpht_pkg::ACT_REMOVE, 32'hFFFF_FFFF, 32'h0, 0, 0);

		// clustered keys near slot 0 and near the top slot so probe chains form and wrap
		for (int i = 0; i < POOL_SIZE; i++) begin
			key = (i % 2) ? 32'($urandom_range(0, 7)) : 32'($urandom_range(248, 254));
			key = key + 32'd255 * 32'($urandom_range(0, 16843008));
			key_pool[i] = key;
		end

		for (int p = 0; p < 4; p++) begin
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				roll = $urandom_range(0, 99);
				if (roll < 40)
					action = lpht_pkg::ACT_SET;
				else if (roll < 70)
					action = lpht_pkg::ACT_GET;
				else if (roll < 95)
					action = lpht_pkg::ACT_REMOVE;
				else
					action = ACT_UNUSED;
				key = ($urandom_range(0, 9) == 0) ? $urandom
					: key_pool[$urandom_range(0, POOL_SIZE - 1)];
				roll = $urandom_range(0, 9);
				data = (roll == 0) ? 32'h0 : (roll == 1) ? 32'hFFFF_FFFF : $urandom;
				add_op(action, key, data, idle_mode[p], stall_mode[p]);
			end
		end

		// fill the table until it answers full, then probe it at full length
		for (int i = 0; i < 270; i++) begin
			key = $urandom;
			fill_keys.push_back(key);
			add_op(lpht_pkg::ACT_SET, key, $urandom, idle_mode[3], stall_mode[3]);
		end
		for (int i = 0; i < 10; i++) begin
			roll = $urandom_range(0, 3);
			key = (roll == 0) ? $urandom : fill_keys[$urandom_range(0, fill_keys.size() - 1)];
			action = (roll == 1) ? lpht_pkg::ACT_REMOVE
				: (roll == 2) ? lpht_pkg::ACT_SET : lpht_pkg::ACT_GET;
			add_op(action, key, $urandom, idle_mode[3], stall_mode[3]);
		end
		add_op(lpht_pkg::ACT_SET, $urandom, $urandom, idle_mode[3], stall_mode[3]);

		total_items = pending_ops.size();

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		wait (items_accepted == total_items);
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#40_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule

/* files.f */
src/lpht_pkg.sv
src/lpht_hash.sv
src/lpht_ram.sv
src/linear_probe_hash_table.sv
dv/linear_probe_hash_table_tb.sv
